@@ src/pov_pkg.sv @@
package pov_pkg;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned SLOT_BITS = $clog2(SLOTS);
  localparam int unsigned DIV_BITS = COUNT_BITS + SLOT_BITS;
  localparam int unsigned CNT_W = $clog2(DIV_BITS);

  localparam int unsigned SPACING_W = 8;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned SLOT_FIELD_W = 8;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 8'd21;
  localparam logic [WORD_W-1:0] WORD_RESET = 16'h8000;

  localparam logic REG_MARK_SPACING = 1'b0;
  localparam logic REG_MARK_WORD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_QUO,
    ST_LOADM,
    ST_MOD,
    ST_DONE
  } pov_state_e;

  typedef struct packed {
    logic upd;
    logic load_q;
    logic load_m;
    logic step;
    logic write_out;
  } pov_cmd_t;

  typedef struct packed {
    logic period_zero;
    logic spacing_zero;
  } pov_sts_t;

  typedef struct packed {
    logic [SPACING_W-1:0] spacing;
    logic [WORD_W-1:0] word;
  } pov_cfg_t;

endpackage

@@ src/pov_regs.sv @@
module pov_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pov_pkg::ADDR_W-1:0]  paddr,
  input  logic [pov_pkg::DATA_W-1:0]  pwdata,
  output logic [pov_pkg::DATA_W-1:0]  prdata,
  output pov_pkg::pov_cfg_t           cfg_o
);
  import pov_pkg::*;

  logic [SPACING_W-1:0] spacing_q, spacing_d;
  logic [WORD_W-1:0]    word_q, word_d;
  logic                 wr_en;

  // Registers sit on word boundaries, so only bit 2 of the address selects one.
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    spacing_d = spacing_q;
    word_d = word_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_MARK_SPACING: spacing_d = pwdata[SPACING_W-1:0];
        REG_MARK_WORD:    word_d = pwdata[WORD_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= SPACING_RESET;
      word_q <= WORD_RESET;
    end else begin
      spacing_q <= spacing_d;
      word_q <= word_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MARK_SPACING: prdata = DATA_W'(spacing_q);
      REG_MARK_WORD:    prdata = DATA_W'(word_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.spacing = spacing_q;
  assign cfg_o.word = word_q;

endmodule

@@ src/pov_ctrl.sv @@
module pov_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  pov_pkg::pov_sts_t  sts_i,
  output pov_pkg::pov_cmd_t  cmd_o
);
  import pov_pkg::*;

  pov_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.upd = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.period_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.load_q = 1'b1;
          cnt_d = CNT_W'(DIV_BITS - 1);
          state_d = ST_QUO;
        end
      end
      ST_QUO: begin
        cmd_o.step = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_LOADM;
        end
      end
      ST_LOADM: begin
        cmd_o.load_m = 1'b1;
        if (sts_i.spacing_zero) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = CNT_W'(SLOT_BITS - 1);
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.step = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.write_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/pov_dpath.sv @@
module pov_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pov_pkg::pov_cmd_t                cmd_i,
  input  pov_pkg::pov_cfg_t                cfg_i,
  input  logic                             hall_pulse_i,
  output pov_pkg::pov_sts_t                sts_o,
  output logic [pov_pkg::SLOT_FIELD_W-1:0] slot_o,
  output logic [pov_pkg::WORD_W-1:0]       led_word_o,
  output logic                             slot_valid_o
);
  import pov_pkg::*;

  logic [COUNT_BITS-1:0]   tick_q, tick_d;
  logic [COUNT_BITS-1:0]   period_q, period_d;
  logic [DIV_BITS-1:0]     dvd_q, dvd_d;
  logic [COUNT_BITS-1:0]   dvs_q, dvs_d;
  logic [COUNT_BITS-1:0]   rem_q, rem_d;
  logic [SLOT_BITS-1:0]    quo_q, quo_d;
  logic [SLOT_BITS-1:0]    slot_q, slot_d;
  logic [SLOT_FIELD_W-1:0] out_slot_q;
  logic [WORD_W-1:0]       out_led_q;
  logic                    out_valid_q;
  logic [COUNT_BITS:0]     rem_sh;
  logic [COUNT_BITS:0]     rem_sub;
  logic                    fits;
  logic                    mark;

  always_comb begin
    tick_d = tick_q;
    period_d = period_q;
    if (cmd_i.upd) begin
      if (hall_pulse_i) begin
        period_d = tick_q;
        tick_d = '0;
      end else begin
        tick_d = tick_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      period_q <= '0;
    end else begin
      tick_q <= tick_d;
      period_q <= period_d;
    end
  end

  // Restoring division, one quotient bit per cycle. Only the low quotient bits are
  // kept, which is the slot reduced modulo the slot count.
  assign rem_sh = {rem_q, dvd_q[DIV_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits = !rem_sub[COUNT_BITS];

  always_comb begin
    dvd_d = dvd_q;
    dvs_d = dvs_q;
    rem_d = rem_q;
    quo_d = quo_q;
    slot_d = slot_q;
    if (cmd_i.load_q) begin
      dvd_d = {tick_q, SLOT_BITS'(0)};
      dvs_d = period_q;
      rem_d = '0;
      quo_d = '0;
    end else if (cmd_i.load_m) begin
      // The second pass reuses the divider to find slot modulo mark spacing.
      slot_d = quo_q;
      dvd_d = {quo_q, COUNT_BITS'(0)};
      dvs_d = COUNT_BITS'(cfg_i.spacing);
      rem_d = '0;
      quo_d = '0;
    end else if (cmd_i.step) begin
      dvd_d = {dvd_q[DIV_BITS-2:0], 1'b0};
      rem_d = fits ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
      quo_d = {quo_q[SLOT_BITS-2:0], fits};
    end
  end

  assign mark = (period_q != '0) && (cfg_i.spacing != '0) && (rem_q == '0);

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    slot_q <= slot_d;
    if (cmd_i.write_out) begin
      out_slot_q <= (period_q == '0) ? '0 : slot_q[SLOT_FIELD_W-1:0];
      out_led_q <= mark ? cfg_i.word : '0;
      out_valid_q <= (period_q != '0);
    end
  end

  assign sts_o.period_zero = (period_q == '0);
  assign sts_o.spacing_zero = (cfg_i.spacing == '0);
  assign slot_o = out_slot_q;
  assign led_word_o = out_led_q;
  assign slot_valid_o = out_valid_q;

endmodule

@@ src/pov_angular_slot_tracker.sv @@
// Angular slot tracker for a persistence-of-vision display. Each request is one
// prescaled timer tick with its hall flag; the block answers each with the angular
// slot, the LED word for that slot and a flag that says whether a revolution period
// is known. A request whose period is known passes the LOAD, QUO, LOADM, MOD and
// DONE states from acceptance to its result, and the next request is taken only
// back in IDLE, so one request is worked on at a time. QUO and MOD drive a shared
// restoring divider that runs 24 single-bit steps for the slot and then 8 steps
// for the mark-spacing test. A request with no known period goes from LOAD to
// DONE, and one with zero mark spacing from LOADM to DONE. A finished result waits
// in an output register, so the next request is taken while it is still stalled.
module pov_angular_slot_tracker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             hall_pulse_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [pov_pkg::SLOT_FIELD_W-1:0] slot_o,
  output logic [pov_pkg::WORD_W-1:0]       led_word_o,
  output logic                             slot_valid_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pov_pkg::ADDR_W-1:0]       paddr,
  input  logic [pov_pkg::DATA_W-1:0]       pwdata,
  output logic [pov_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import pov_pkg::*;

  pov_cfg_t cfg;
  pov_cmd_t cmd;
  pov_sts_t sts;

  assign pready = 1'b1;

  pov_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  pov_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pov_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .hall_pulse_i (hall_pulse_i),
    .sts_o        (sts),
    .slot_o       (slot_o),
    .led_word_o   (led_word_o),
    .slot_valid_o (slot_valid_o)
  );

endmodule

@@ src/pov_chk.sv @@
module pov_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [pov_pkg::SLOT_FIELD_W-1:0] slot_o,
  input logic [pov_pkg::WORD_W-1:0]       led_word_o,
  input logic                             slot_valid_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_o)
      && $stable(led_word_o) && $stable(slot_valid_o))
    else $error("stalled result changed");

  // Without a known period the slot and LED word read zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !slot_valid_o |-> slot_o == '0 && led_word_o == '0)
    else $error("invalid slot with nonzero payload");

  // One request at a time: once a request is taken, the block reports a stall while it works on it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("request accepted while busy");

  // A new result only ever comes out of work in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in progress");

endmodule

bind pov_angular_slot_tracker pov_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .slot_o       (slot_o),
  .led_word_o   (led_word_o),
  .slot_valid_o (slot_valid_o)
);

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pov_pkg::*;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] slot;
    logic [WORD_W-1:0]       led_word;
    logic                    slot_valid;
  } slot_result_t;

  localparam logic [0:24] DIRECTED_HALL = 25'b0010001101001100001000000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    hall_pulse_i = 1'b0;
  logic                    out_stall_i = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic [SLOT_FIELD_W-1:0] slot_o;
  logic [WORD_W-1:0]       led_word_o;
  logic                    slot_valid_o;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  // Shadow of the tracker state and its registers.
  logic [COUNT_BITS-1:0]   rotor_count = '0;
  logic [COUNT_BITS-1:0]   rotor_period = '0;
  logic [SPACING_W-1:0]    mark_spacing_q = SPACING_RESET;
  logic [WORD_W-1:0]       mark_word_q = WORD_RESET;

  logic                    tick_queue[$];
  slot_result_t            awaited_slots[$];
  logic                    req_taken = 1'b0;

  int err_cnt = 0;
  int ticks_taken = 0;
  int results_seen = 0;
  int marked_cnt = 0;
  int beyond_cnt = 0;
  int no_period_cnt = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int next_hold_at = 150;
  int stall_phase = 0;
  int stall_mode = 0;

  pov_angular_slot_tracker u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hall_pulse_i (hall_pulse_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .slot_o       (slot_o),
    .led_word_o   (led_word_o),
    .slot_valid_o (slot_valid_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk_i = ~clk_i;

  function automatic slot_result_t advance_rotor(input logic hall);
    slot_result_t     res;
    longint unsigned  angle;
    res = '0;
    if (hall) begin
      rotor_period = rotor_count;
      rotor_count = '0;
    end else begin
      rotor_count = rotor_count + 1'b1;
    end
    if (rotor_period != '0) begin
      angle = longint'(SLOTS);
      angle = (angle * rotor_count) / rotor_period;
      angle = angle % SLOTS;
      res.slot_valid = 1'b1;
      res.slot = angle[SLOT_FIELD_W-1:0];
      if (rotor_count > rotor_period) beyond_cnt++;
      if (mark_spacing_q != '0 && angle % mark_spacing_q == 0) begin
        res.led_word = mark_word_q;
        marked_cnt++;
      end
    end else begin
      no_period_cnt++;
    end
    return res;
  endfunction

  // One revolution: the hall pulse followed by len plain ticks.
  task automatic add_rev(input int len);
    tick_queue.push_back(1'b1);
    repeat (len) tick_queue.push_back(1'b0);
  endtask

  task automatic queue_short_revs(input int n);
    int added;
    int pick;
    int len;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        len = $urandom_range(1, 6);
        repeat (len) tick_queue.push_back($urandom_range(0, 3) == 0);
        added += len;
      end else if (pick < 14) begin
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b1);
        added += 2;
      end else begin
        len = (pick < 24) ? $urandom_range(41, 120) : $urandom_range(2, 40);
        add_rev(len);
        added += len + 1;
      end
    end
  endtask

  task automatic wait_idle;
    @(posedge clk_i);
    while (tick_queue.size() != 0 || in_valid_i || awaited_slots.size() != 0)
      @(posedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // Writes a register, then reads it back.
  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] want;
    logic [DATA_W-1:0] got;
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_MARK_SPACING) mark_spacing_q = value[SPACING_W-1:0];
    else mark_word_q = value[WORD_W-1:0];
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_MARK_SPACING) begin
      want = {{(DATA_W-SPACING_W){1'b0}}, mark_spacing_q};
      got = {{(DATA_W-SPACING_W){1'b0}}, prdata[SPACING_W-1:0]};
    end else begin
      want = {{(DATA_W-WORD_W){1'b0}}, mark_word_q};
      got = {{(DATA_W-WORD_W){1'b0}}, prdata[WORD_W-1:0]};
    end
    if (got !== want) begin
      $display("%0t: register %0d read back expected %0h, got %0h", $time, idx, want, got);
      err_cnt++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !req_taken)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        hall_pulse_i <= 1'($urandom_range(0, 1));
        gap_left--;
      end else if (tick_queue.size() != 0) begin
        in_valid_i <= 1'b1;
        hall_pulse_i <= tick_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
        hall_pulse_i <= 1'($urandom_range(0, 1));
      end
    end
  end

  // The receiver moves at random among four stall patterns, and twice holds off
  // for a long stretch so that the block backs up into its input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (holds_done < 2 && results_seen >= next_hold_at) begin
        out_stall_i <= 1'b1;
        hold_left = HOLD_CYCLES;
        holds_done++;
        next_hold_at += 400;
      end else begin
        stall_phase++;
        if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    slot_result_t want;
    if (rst_ni) begin
      req_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (awaited_slots.size() == 0) begin
          $display("%0t: result with none expected, got slot %0d led %0h valid %0b",
                   $time, slot_o, led_word_o, slot_valid_o);
          err_cnt++;
        end else begin
          want = awaited_slots.pop_front();
          if (slot_o !== want.slot) begin
            $display("%0t: slot expected %0d, got %0d", $time, want.slot, slot_o);
            err_cnt++;
          end
          if (led_word_o !== want.led_word) begin
            $display("%0t: led_word expected %0h, got %0h", $time, want.led_word, led_word_o);
            err_cnt++;
          end
          if (slot_valid_o !== want.slot_valid) begin
            $display("%0t: slot_valid expected %0b, got %0b", $time, want.slot_valid,
                     slot_valid_o);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        awaited_slots.push_back(advance_rotor(hall_pulse_i));
        ticks_taken++;
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: no period yet, zero periods, wrapping and marked slots.
    for (int i = 0; i < 25; i++) tick_queue.push_back(DIRECTED_HALL[i]);
    wait_idle();

    write_reg(REG_MARK_SPACING, 32'd1);
    write_reg(REG_MARK_WORD, 32'h0000_FFFF);
    queue_short_revs(90);
    wait_idle();

    // A period of 256 ticks and beyond reaches the top slots.
    write_reg(REG_MARK_SPACING, 32'd255);
    write_reg(REG_MARK_WORD, $urandom_range(0, 16'hFFFF));
    add_rev(256);
    add_rev($urandom_range(256, 300));
    queue_short_revs(20);
    wait_idle();

    write_reg(REG_MARK_SPACING, 32'd0);
    write_reg(REG_MARK_WORD, 32'h0000_FFFF);
    queue_short_revs(60);
    wait_idle();

    write_reg(REG_MARK_SPACING, $urandom_range(2, 32));
    write_reg(REG_MARK_WORD, 32'd0);
    queue_short_revs(60);
    wait_idle();

    write_reg(REG_MARK_SPACING, $urandom_range(1, 255));
    write_reg(REG_MARK_WORD, $urandom_range(0, 16'hFFFF));
    queue_short_revs(70);
    wait_idle();

    $display("Checked %0d slot results from %0d ticks over six register settings;",
             results_seen, ticks_taken);
    $display("%0d fell on marked slots, %0d ran past the period, %0d had no period.",
             marked_cnt, beyond_cnt, no_period_cnt);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
src/pov_pkg.sv
src/pov_regs.sv
src/pov_ctrl.sv
src/pov_dpath.sv
src/pov_angular_slot_tracker.sv
src/pov_chk.sv
bench/tb.sv
